### hw/rtl/qrfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrfs_pkg
// shared types and constants of the request queue fade sequencer
// ----------------------------------------------------------------------------
package qrfs_pkg;

    localparam int NUM_DEV = 8;
    localparam int ID_W    = 3;
    localparam int CNT_W   = 4;
    localparam int FADE_W  = 10;
    localparam int POS_W   = 18;
    localparam int FRM_W   = 16;
    localparam int NUM_W   = 18;
    localparam int ALPHA_W = 8;

    localparam logic [FADE_W-1:0]  FADE_RESET = 10'd30;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX  = 8'd255;

    localparam logic [1:0] REPLY_WAIT   = 2'd0;
    localparam logic [1:0] REPLY_NOW    = 2'd1;
    localparam logic [1:0] REPLY_FINISH = 2'd2;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_NOW,
        ST_ALPHA,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic            del;
        logic [ID_W-1:0] dev;
    } t_cell_ctl;

endpackage

### hw/rtl/qrfs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrfs_cell
// one queue slot: holds a device id, shifts toward the head on removal
// ----------------------------------------------------------------------------
module qrfs_cell (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  qrfs_pkg::t_cell_ctl       i_ctl,
    input  logic                      i_shift,
    input  logic [qrfs_pkg::ID_W-1:0] i_next_id,
    output logic [qrfs_pkg::ID_W-1:0] o_id,
    output logic                      o_shift
);
    import qrfs_pkg::*;

    logic [ID_W-1:0] r_id;

    // every slot from the match onward takes its neighbor's id
    assign o_shift = i_shift | (i_ctl.del & (r_id == i_ctl.dev));
    assign o_id    = r_id;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_id <= i_ctl.dev;
        end else if (i_ctl.del && o_shift) begin
            r_id <= i_next_id;
        end
    end

endmodule

### hw/rtl/qrfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrfs_div
// restoring divider, one quotient bit per cycle, quotient below 256
// ----------------------------------------------------------------------------
module qrfs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [qrfs_pkg::NUM_W-1:0]   i_num,
    input  logic [qrfs_pkg::FADE_W-1:0]  i_den,
    output logic                         o_done,
    output logic [qrfs_pkg::ALPHA_W-1:0] o_quot
);
    import qrfs_pkg::*;

    logic                r_run;
    logic [2:0]          r_cnt;
    logic [FADE_W-1:0]   r_rem;
    logic [FADE_W-1:0]   r_den;
    logic [ALPHA_W-1:0]  r_bits;
    logic                r_done;
    logic [FADE_W:0]     w_trial;
    logic [FADE_W:0]     w_diff;

    assign w_trial = {r_rem, r_bits[ALPHA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits replace numerator bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num[NUM_W-1:ALPHA_W];
            r_bits <= i_num[ALPHA_W-1:0];
            r_den  <= i_den;
        end else if (r_run) begin
            if (!w_diff[FADE_W]) begin
                r_rem  <= w_diff[FADE_W-1:0];
                r_bits <= {r_bits[ALPHA_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial[FADE_W-1:0];
                r_bits <= {r_bits[ALPHA_W-2:0], 1'b0};
            end
        end
    end

endmodule

### hw/rtl/request_queue_fade_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_queue_fade_sequencer_top
// device request queue with overlay start, fade-out and alpha ramp per tick
// ----------------------------------------------------------------------------
// channel   | handshake                        | beat
// command   | start && !busy                   | mode, device, active, frames
// result    | o_strobe, one cycle, no stall    | kind .. last
// config    | psel && penable && pwrite        | fade_frames at address 0
//
// a report gives at most two reply beats, the second only when the queue head leaves
// a tick steps through eval, now if the head left, alpha, the 8 step alpha divider if needed, and out
// busy stays high until the last beat of the command, if any, is on the result ports
// reset is synchronous; the queue slots hold no reset value, the count does
// ----------------------------------------------------------------------------
module request_queue_fade_sequencer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [qrfs_pkg::ID_W-1:0]     i_device,
    input  logic                          i_active,
    input  logic [qrfs_pkg::FRM_W-1:0]    i_current_frame,
    input  logic [qrfs_pkg::FRM_W-1:0]    i_total_frames,
    output logic                          o_strobe,
    output logic                          o_kind,
    output logic [qrfs_pkg::ID_W-1:0]     o_target_device,
    output logic [1:0]                    o_reply,
    output logic [qrfs_pkg::ALPHA_W-1:0]  o_opacity,
    output logic                          o_overlay_on,
    output logic [qrfs_pkg::ID_W-1:0]     o_overlay_owner,
    output logic                          o_start_play,
    output logic                          o_background_paused,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import qrfs_pkg::*;

    t_state r_state, n_state;

    logic [FADE_W-1:0]  r_fade;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [NUM_DEV-1:0] r_mask, n_mask;
    logic               r_ov, n_ov;
    logic [ID_W-1:0]    r_ovid, n_ovid;
    logic signed [POS_W-1:0] r_fb, n_fb, r_fe, n_fe, r_f, n_f;
    logic [ALPHA_W-1:0] r_alpha, n_alpha;
    logic               r_bg, n_bg;
    logic               r_startp, n_startp;

    logic               r_mode, r_act;
    logic [ID_W-1:0]    r_dev;
    logic [FRM_W-1:0]   r_cur, r_total;

    logic               r_ostb, n_ostb;
    logic               r_okind, n_okind;
    logic [ID_W-1:0]    r_otgt, n_otgt;
    logic [1:0]         r_orep, n_orep;
    logic               r_olast, n_olast;
    logic               r_otick, n_otick;

    // queue cells
    t_cell_ctl          w_ctl;
    logic [NUM_DEV-1:0] w_load;
    logic [ID_W-1:0]    w_ids [NUM_DEV];
    logic [NUM_DEV:0]   w_shift;

    logic               w_div_start, w_div_done;
    logic [NUM_W-1:0]   w_div_num;
    logic [FADE_W-1:0]  w_div_den;
    logic [ALPHA_W-1:0] w_div_q;

    logic               w_enq;
    logic               w_cfg_wr;

    assign w_shift[0] = 1'b0;

    for (genvar g = 0; g < NUM_DEV; g++) begin : g_cell
        logic [ID_W-1:0] w_next;
        if (g == NUM_DEV - 1) begin : g_end
            assign w_next = w_ids[g];
        end else begin : g_mid
            assign w_next = w_ids[g+1];
        end
        assign w_load[g] = w_enq && (r_count == CNT_W'(g));
        qrfs_cell u_cell (
            .i_clk     (i_clk),
            .i_load    (w_load[g]),
            .i_ctl     (w_ctl),
            .i_shift   (w_shift[g]),
            .i_next_id (w_next),
            .o_id      (w_ids[g]),
            .o_shift   (w_shift[g+1])
        );
    end

    qrfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata   = (paddr == 3'd0) ? {22'd0, r_fade} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade <= FADE_RESET;
        end else if (w_cfg_wr) begin
            r_fade <= pwdata[FADE_W-1:0];
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode  <= i_mode;
            r_dev   <= i_device;
            r_act   <= i_active;
            r_cur   <= i_current_frame;
            r_total <= i_total_frames;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_mask   <= '0;
            r_ov     <= 1'b0;
            r_ovid   <= '0;
            r_fb     <= '0;
            r_fe     <= '0;
            r_f      <= '0;
            r_alpha  <= ALPHA_MAX;
            r_bg     <= 1'b0;
            r_startp <= 1'b0;
            r_ostb   <= 1'b0;
            r_okind  <= KIND_REPLY;
            r_otgt   <= '0;
            r_orep   <= REPLY_WAIT;
            r_olast  <= 1'b0;
            r_otick  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_mask   <= n_mask;
            r_ov     <= n_ov;
            r_ovid   <= n_ovid;
            r_fb     <= n_fb;
            r_fe     <= n_fe;
            r_f      <= n_f;
            r_alpha  <= n_alpha;
            r_bg     <= n_bg;
            r_startp <= n_startp;
            r_ostb   <= n_ostb;
            r_okind  <= n_okind;
            r_otgt   <= n_otgt;
            r_orep   <= n_orep;
            r_olast  <= n_olast;
            r_otick  <= n_otick;
        end
    end

    logic                    w_in1, w_in2, w_outside, w_lastf;
    logic signed [POS_W-1:0] w_cur, w_fade, w_nb;
    logic [POS_W-1:0]        w_n, w_d;
    logic [FADE_W-1:0]       w_dn;
    logic                    w_head_hit;

    assign w_cur  = {2'b00, r_cur};
    assign w_fade = {8'd0, r_fade};
    assign w_nb   = w_cur + 18'sd1;
    assign w_outside = !(w_cur <= w_fade) && !(w_cur >= r_fb && w_cur <= r_fe);
    assign w_lastf   = (w_cur == r_fe);
    assign w_in1  = (r_f >= 18'sd0) && (r_f <= w_fade);
    assign w_in2  = (r_f >= r_fb) && (r_f <= r_fe);
    assign w_n    = POS_W'(r_f - r_fb);
    assign w_d    = POS_W'(r_fe - r_fb);
    assign w_dn   = w_d[FADE_W-1:0] - w_n[FADE_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mask      = r_mask;
        n_ov        = r_ov;
        n_ovid      = r_ovid;
        n_fb        = r_fb;
        n_fe        = r_fe;
        n_f         = r_f;
        n_alpha     = r_alpha;
        n_bg        = r_bg;
        n_startp    = r_startp;
        n_ostb      = 1'b0;
        n_okind     = KIND_REPLY;
        n_otgt      = '0;
        n_orep      = REPLY_WAIT;
        n_olast     = 1'b0;
        n_otick     = 1'b0;
        w_enq       = 1'b0;
        w_ctl.del   = 1'b0;
        w_ctl.dev   = r_dev;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = r_fade;
        w_head_hit  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_IDLE;
                if (!r_mode) begin
                    if (r_act && !r_mask[r_dev]) begin
                        if (r_count < CNT_W'(NUM_DEV)) begin
                            w_enq          = 1'b1;
                            n_count        = r_count + CNT_W'(1);
                            n_mask[r_dev]  = 1'b1;
                            n_ostb         = 1'b1;
                            n_otgt         = r_dev;
                            n_orep         = (r_count != '0) ? REPLY_WAIT : REPLY_NOW;
                            n_olast        = 1'b1;
                        end
                    end else if (!r_act && r_mask[r_dev]) begin
                        w_ctl.del     = 1'b1;
                        w_head_hit    = (w_ids[0] == r_dev) && (r_count > CNT_W'(1));
                        n_count       = r_count - CNT_W'(1);
                        n_mask[r_dev] = 1'b0;
                        n_ostb        = 1'b1;
                        n_otgt        = r_dev;
                        n_orep        = REPLY_FINISH;
                        n_olast       = !w_head_hit;
                        if (w_head_hit) begin
                            n_state = ST_NOW;
                        end
                    end
                end else begin
                    n_state  = ST_ALPHA;
                    n_startp = 1'b0;
                    n_f      = w_cur;
                    if (r_ov) begin
                        if (w_outside) begin
                            if (r_count == '0 || r_ovid != w_ids[0]) begin
                                n_fb = w_nb;
                                n_fe = w_nb + w_fade;
                            end
                        end else if (w_lastf) begin
                            n_ov = 1'b0;
                            // the owner may already have left the queue
                            if (r_count != '0 && r_mask[r_ovid]) begin
                                w_ctl.del      = 1'b1;
                                w_ctl.dev      = r_ovid;
                                w_head_hit     = (w_ids[0] == r_ovid) &&
                                                 (r_count > CNT_W'(1));
                                n_count        = r_count - CNT_W'(1);
                                n_mask[r_ovid] = 1'b0;
                                n_ostb         = 1'b1;
                                n_otgt         = r_ovid;
                                n_orep         = REPLY_FINISH;
                                if (w_head_hit) begin
                                    n_state = ST_NOW;
                                end
                            end
                        end
                    end else if (r_count != '0) begin
                        n_ov     = 1'b1;
                        n_ovid   = w_ids[0];
                        n_fe     = {2'b00, r_total};
                        n_fb     = {2'b00, r_total} - w_fade;
                        n_startp = 1'b1;
                        n_f      = '0;
                    end
                end
            end
            ST_NOW: begin
                n_ostb  = 1'b1;
                n_otgt  = w_ids[0];
                n_orep  = REPLY_NOW;
                n_olast = !r_mode;
                n_state = r_mode ? ST_ALPHA : ST_IDLE;
            end
            ST_ALPHA: begin
                n_state = ST_OUT;
                if (r_ov) begin
                    n_bg = !w_in1 && !w_in2;
                    if (w_in1) begin
                        if (r_fade == '0) begin
                            n_alpha = ALPHA_MAX;
                        end else begin
                            w_div_start = 1'b1;
                            w_div_num   = NUM_W'({r_f[FADE_W-1:0], 8'd0}) -
                                          NUM_W'(r_f[FADE_W-1:0]);
                            n_state     = ST_DIV;
                        end
                    end else if (w_in2) begin
                        if (w_d == '0) begin
                            n_alpha = ALPHA_MAX;
                        end else begin
                            w_div_start = 1'b1;
                            w_div_num   = NUM_W'({w_dn, 8'd0}) - NUM_W'(w_dn);
                            w_div_den   = w_d[FADE_W-1:0];
                            n_state     = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_alpha = w_div_q;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                n_ostb  = 1'b1;
                n_okind = KIND_TICK;
                n_otick = 1'b1;
                n_olast = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy                = (r_state != ST_IDLE);
    assign o_strobe            = r_ostb;
    assign o_kind              = r_okind;
    assign o_target_device     = r_otgt;
    assign o_reply             = r_orep;
    assign o_last              = r_olast;
    assign o_opacity           = r_otick ? r_alpha : '0;
    assign o_overlay_on        = r_otick & r_ov;
    assign o_overlay_owner     = (r_otick && r_ov) ? r_ovid : '0;
    assign o_start_play        = r_otick & r_startp;
    assign o_background_paused = r_otick & r_bg;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_DEV))
        else $error("queue count above depth");

    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_mask) == int'(r_count))
        else $error("membership bits disagree with queue count");

    a_beat_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result beat with no command in progress");

    a_reply_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == KIND_REPLY) |-> (o_opacity == '0 && !o_overlay_on))
        else $error("device reply carries tick status");

endmodule
